/* rtl/core/fault_log_ring_dedup_defines.svh */
// ----------------------------------------------------------------------------
// Fault log assertion macros
// Shared concurrent assertion shorthands for the fault log design.
// ----------------------------------------------------------------------------
`ifndef FAULT_LOG_RING_DEDUP_DEFINES_SVH
`define FAULT_LOG_RING_DEDUP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FLRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define FLRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/flrd_pkg.sv */
// ----------------------------------------------------------------------------
// Fault log package
// Types, constants and helpers shared by the fault log design.
// ----------------------------------------------------------------------------
package flrd_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int HELD_W        = 5;

   // request command codes
   localparam logic [1:0] CMD_RECORD   = 2'd0;
   localparam logic [1:0] CMD_SET_TIME = 2'd1;
   localparam logic [1:0] CMD_SNAPSHOT = 2'd2;

   localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

   // one stored record
   typedef struct packed {
      logic [31:0] sequence_no;
      logic [15:0] domain;
      logic [15:0] stage;
      logic [31:0] code;
      logic [31:0] ctx;
      logic [31:0] count;
      logic [31:0] time_ms;
   } rec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REC_RD,
      ST_REC_UPD,
      ST_SNAP_RD,
      ST_SNAP_LD,
      ST_SNAP_OUT
   } state_type;

   // shared incrementer modes
   typedef enum logic {
      INC_SKIP_ZERO,
      INC_SATURATE
   } inc_mode_type;

endpackage

/* rtl/core/flrd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module flrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/fault_log_ring_dedup.sv */
// ----------------------------------------------------------------------------
// Fault log ring with duplicate merging
// Ring of DEPTH fault records; repeats of the newest record are merged.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ valid/ready channel; req_cmd selects record,
//   set board time or snapshot. Snapshot results leave on the rsp_ channel.
//   A record request passes through accept, read of the newest record from
//   the record RAM, then compare and write back; set time produces nothing;
//   unused command codes are dropped. A snapshot streams the held records
//   oldest first. Each result passes through one RAM read, one load of the
//   output register and the handshake, which waits while rsp_ready stays
//   low. An empty log gives a single result with rsp_entry_valid low,
//   presented in the cycle right after acceptance. req_ready is high only
//   while no request is in progress, so a stalled receiver holds off new
//   requests. The serial, count and eviction updates share one 32-bit
//   incrementer, used at most once per sequencer step. Reset clears the
//   counters, fill level and write slot; the record RAM is not cleared,
//   since the contents of unwritten entries are never used.
// ----------------------------------------------------------------------------
`include "fault_log_ring_dedup_defines.svh"

module fault_log_ring_dedup
   import flrd_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [15:0]       req_fault_domain,
   input  logic [15:0]       req_fault_stage,
   input  logic [31:0]       req_fault_code,
   input  logic [31:0]       req_fault_context,
   input  logic [31:0]       req_time_ms,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_entry_valid,
   output logic [31:0]       rsp_entry_sequence,
   output logic [15:0]       rsp_entry_domain,
   output logic [15:0]       rsp_entry_stage,
   output logic [31:0]       rsp_entry_code,
   output logic [31:0]       rsp_entry_context,
   output logic [31:0]       rsp_entry_count,
   output logic [31:0]       rsp_entry_time,
   output logic [31:0]       rsp_log_serial,
   output logic [31:0]       rsp_evicted_total,
   output logic [HELD_W-1:0] rsp_held_count,
   output logic              rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [FW-1:0] FULL_LVL  = FW'(DEPTH);

   state_type state_ff, state_in;

   logic [31:0]   serial_ff, serial_in;
   logic [31:0]   evict_ff, evict_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [AW-1:0] wslot_ff, wslot_in;
   logic [31:0]   btime_ff, btime_in;

   // captured record request
   logic [15:0] dom_ff, stg_ff;
   logic [31:0] code_ff, ctx_ff;

   // snapshot walk
   logic [AW-1:0] rptr_ff, rptr_in;
   logic [FW-1:0] rem_ff, rem_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rec_type rsp_rec_ff, rsp_rec_in;
   logic    rsp_ev_ff, rsp_ev_in;
   logic    rsp_last_ff, rsp_last_in;

   // RAM port
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   rec_type       ram_wdata, ram_rdata;

   // shared incrementer
   logic [31:0]  inc_op, inc_sum, inc_res;
   inc_mode_type inc_mode;

   logic          req_fire, rsp_fire, full, match;
   logic [AW-1:0] newest, wslot_next, rptr_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign full      = (fill_ff == FULL_LVL);

   assign newest     = (wslot_ff == '0) ? LAST_SLOT : wslot_ff - AW'(1);
   assign wslot_next = (wslot_ff == LAST_SLOT) ? '0 : wslot_ff + AW'(1);
   assign rptr_next  = (rptr_ff == LAST_SLOT) ? '0 : rptr_ff + AW'(1);

   // newest record repeats the captured fault
   assign match = (fill_ff != '0) && (ram_rdata.domain == dom_ff) &&
                  (ram_rdata.stage == stg_ff) && (ram_rdata.code == code_ff) &&
                  (ram_rdata.ctx == ctx_ff);

   // shared incrementer: serial skips zero, counters saturate
   assign inc_sum = inc_op + 32'd1;
   always_comb begin
      inc_res = inc_sum;
      if (inc_mode == INC_SATURATE && inc_op == U32_MAX) begin
         inc_res = inc_op;
      end else if (inc_mode == INC_SKIP_ZERO && inc_sum == '0) begin
         inc_res = 32'd1;
      end
   end

   flrd_ram #(
      .WIDTH ($bits(rec_type)),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_cmd)
                  CMD_RECORD:   state_in = ST_REC_RD;
                  CMD_SNAPSHOT: state_in = (fill_ff == '0) ? ST_SNAP_OUT : ST_SNAP_RD;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_REC_RD:  state_in = ST_REC_UPD;
         ST_REC_UPD: state_in = ST_IDLE;
         ST_SNAP_RD: state_in = ST_SNAP_LD;
         ST_SNAP_LD: state_in = ST_SNAP_OUT;
         ST_SNAP_OUT: begin
            if (rsp_fire) begin
               state_in = rsp_last_ff ? ST_IDLE : ST_SNAP_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      serial_in    = serial_ff;
      evict_in     = evict_ff;
      fill_in      = fill_ff;
      wslot_in     = wslot_ff;
      btime_in     = btime_ff;
      rptr_in      = rptr_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = wslot_ff;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = newest;
      inc_op       = serial_ff;
      inc_mode     = INC_SKIP_ZERO;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd == CMD_SET_TIME) begin
                  btime_in = req_time_ms;
               end
               // oldest record sits at the write slot once the ring is full
               rptr_in = full ? wslot_ff : '0;
               rem_in  = fill_ff;
               if (req_cmd == CMD_SNAPSHOT && fill_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_rec_in   = '0;
                  rsp_ev_in    = 1'b0;
                  rsp_last_in  = 1'b1;
               end
            end
         end
         ST_REC_RD: begin
            // fetch newest record, advance the serial
            ram_re    = 1'b1;
            ram_raddr = newest;
            serial_in = inc_res;
         end
         ST_REC_UPD: begin
            inc_mode = INC_SATURATE;
            if (match) begin
               inc_op                = ram_rdata.count;
               ram_we                = 1'b1;
               ram_waddr             = newest;
               ram_wdata             = ram_rdata;
               ram_wdata.count       = inc_res;
               ram_wdata.sequence_no = serial_ff;
               ram_wdata.time_ms     = btime_ff;
            end else begin
               inc_op                = evict_ff;
               ram_we                = 1'b1;
               ram_waddr             = wslot_ff;
               ram_wdata.sequence_no = serial_ff;
               ram_wdata.domain      = dom_ff;
               ram_wdata.stage       = stg_ff;
               ram_wdata.code        = code_ff;
               ram_wdata.ctx         = ctx_ff;
               ram_wdata.count       = 32'd1;
               ram_wdata.time_ms     = btime_ff;
               wslot_in              = wslot_next;
               if (full) begin
                  evict_in = inc_res;
               end else begin
                  fill_in = fill_ff + FW'(1);
               end
            end
         end
         ST_SNAP_RD: begin
            ram_re    = 1'b1;
            ram_raddr = rptr_ff;
         end
         ST_SNAP_LD: begin
            rsp_valid_in = 1'b1;
            rsp_rec_in   = ram_rdata;
            rsp_ev_in    = 1'b1;
            rsp_last_in  = (rem_ff == FW'(1));
         end
         ST_SNAP_OUT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               rptr_in      = rptr_next;
               rem_in       = rem_ff - FW'(1);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         serial_ff    <= '0;
         evict_ff     <= '0;
         fill_ff      <= '0;
         wslot_ff     <= '0;
         btime_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         serial_ff    <= serial_in;
         evict_ff     <= evict_in;
         fill_ff      <= fill_in;
         wslot_ff     <= wslot_in;
         btime_ff     <= btime_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         dom_ff  <= req_fault_domain;
         stg_ff  <= req_fault_stage;
         code_ff <= req_fault_code;
         ctx_ff  <= req_fault_context;
      end
      rptr_ff     <= rptr_in;
      rem_ff      <= rem_in;
      rsp_rec_ff  <= rsp_rec_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_valid    = rsp_ev_ff;
   assign rsp_entry_sequence = rsp_rec_ff.sequence_no;
   assign rsp_entry_domain   = rsp_rec_ff.domain;
   assign rsp_entry_stage    = rsp_rec_ff.stage;
   assign rsp_entry_code     = rsp_rec_ff.code;
   assign rsp_entry_context  = rsp_rec_ff.ctx;
   assign rsp_entry_count    = rsp_rec_ff.count;
   assign rsp_entry_time     = rsp_rec_ff.time_ms;
   assign rsp_log_serial     = serial_ff;
   assign rsp_evicted_total  = evict_ff;
   assign rsp_held_count     = HELD_W'(fill_ff);
   assign rsp_last           = rsp_last_ff;

   // checks
   `FLRD_ASSERT_NOW(a_busy_while_rsp, clock, reset, rsp_valid_ff, !req_ready, "ready during response")
   `FLRD_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= FULL_LVL, "fill level overflow")
   `FLRD_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_fire && rsp_last_ff, req_ready, "not idle after last")
   `FLRD_ASSERT_NEXT(a_empty_snap, clock, reset, req_fire && req_cmd == CMD_SNAPSHOT && fill_ff == '0, rsp_valid_ff && !rsp_ev_ff && rsp_last_ff, "bad empty snapshot")

endmodule

/* tb/fault_log_ring_dedup_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault log ring testbench
// Drives record, set-time, snapshot and unused requests into the fault log,
// tracks the ring in a local model and checks every snapshot result against
// it, field by field, in order. Both channels see random stall bursts.
// ----------------------------------------------------------------------------
module fault_log_ring_dedup_tb
   import flrd_pkg::*;
();

   localparam int          LOG_DEPTH   = DEPTH_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam logic [1:0]  CMD_UNUSED  = 2'd3;

   // one expected snapshot result
   typedef struct {
      logic              entry_valid;
      logic [31:0]       sequence_no;
      logic [15:0]       domain;
      logic [15:0]       stage;
      logic [31:0]       code;
      logic [31:0]       ctx;
      logic [31:0]       count;
      logic [31:0]       time_ms;
      logic [31:0]       serial;
      logic [31:0]       evicted;
      logic [HELD_W-1:0] held;
      logic              last;
   } snap_entry_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_cmd = CMD_RECORD;
   logic [15:0]       req_fault_domain = '0;
   logic [15:0]       req_fault_stage = '0;
   logic [31:0]       req_fault_code = '0;
   logic [31:0]       req_fault_context = '0;
   logic [31:0]       req_time_ms = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_entry_valid;
   logic [31:0]       rsp_entry_sequence;
   logic [15:0]       rsp_entry_domain;
   logic [15:0]       rsp_entry_stage;
   logic [31:0]       rsp_entry_code;
   logic [31:0]       rsp_entry_context;
   logic [31:0]       rsp_entry_count;
   logic [31:0]       rsp_entry_time;
   logic [31:0]       rsp_log_serial;
   logic [31:0]       rsp_evicted_total;
   logic [HELD_W-1:0] rsp_held_count;
   logic              rsp_last;

   // local copy of the log
   rec_type     ring_rec [LOG_DEPTH];
   int unsigned ring_fill;
   int unsigned ring_wr_slot;
   logic [31:0] serial_now;
   logic [31:0] evict_now;
   logic [31:0] model_time;

   snap_entry_type snap_expect_q[$];

   bit          idle_on = 1'b1;
   int unsigned stall_left = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned results_checked = 0;
   int unsigned n_records = 0;
   int unsigned n_merged = 0;
   int unsigned n_time_sets = 0;
   int unsigned n_snapshots = 0;
   int unsigned n_dropped = 0;

   fault_log_ring_dedup #(
      .DEPTH(LOG_DEPTH)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_fault_domain  (req_fault_domain),
      .req_fault_stage   (req_fault_stage),
      .req_fault_code    (req_fault_code),
      .req_fault_context (req_fault_context),
      .req_time_ms       (req_time_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_entry_sequence(rsp_entry_sequence),
      .rsp_entry_domain  (rsp_entry_domain),
      .rsp_entry_stage   (rsp_entry_stage),
      .rsp_entry_code    (rsp_entry_code),
      .rsp_entry_context (rsp_entry_context),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_entry_time    (rsp_entry_time),
      .rsp_log_serial    (rsp_log_serial),
      .rsp_evicted_total (rsp_evicted_total),
      .rsp_held_count    (rsp_held_count),
      .rsp_last          (rsp_last)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, snap_expect_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver stalls: random bursts of low ready while idle_on is set
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // log model
   // ------------------------------------------------------------------
   task automatic model_reset();
      foreach (ring_rec[i]) ring_rec[i] = '0;
      ring_fill    = 0;
      ring_wr_slot = 0;
      serial_now   = '0;
      evict_now    = '0;
      model_time   = '0;
   endtask

   // record: merge with the newest entry or write a fresh one
   task automatic log_fault(logic [15:0] dom, logic [15:0] stg,
                            logic [31:0] code, logic [31:0] ctx);
      int unsigned newest;
      newest = (ring_wr_slot + LOG_DEPTH - 1) % LOG_DEPTH;
      serial_now = serial_now + 32'd1;
      if (serial_now == '0) serial_now = 32'd1;
      if (ring_fill != 0 && ring_rec[newest].domain == dom &&
          ring_rec[newest].stage == stg && ring_rec[newest].code == code &&
          ring_rec[newest].ctx == ctx) begin
         if (ring_rec[newest].count != U32_MAX)
            ring_rec[newest].count = ring_rec[newest].count + 32'd1;
         ring_rec[newest].sequence_no = serial_now;
         ring_rec[newest].time_ms     = model_time;
         n_merged++;
      end else begin
         if (ring_fill >= LOG_DEPTH && evict_now != U32_MAX)
            evict_now = evict_now + 32'd1;
         ring_rec[ring_wr_slot].sequence_no = serial_now;
         ring_rec[ring_wr_slot].domain      = dom;
         ring_rec[ring_wr_slot].stage       = stg;
         ring_rec[ring_wr_slot].code        = code;
         ring_rec[ring_wr_slot].ctx         = ctx;
         ring_rec[ring_wr_slot].count       = 32'd1;
         ring_rec[ring_wr_slot].time_ms     = model_time;
         ring_wr_slot = (ring_wr_slot + 1) % LOG_DEPTH;
         if (ring_fill < LOG_DEPTH) ring_fill++;
      end
   endtask

   // snapshot: held records oldest first, or one empty marker
   task automatic queue_snapshot();
      snap_entry_type e;
      int unsigned idx;
      e = '{default: '0};
      e.serial  = serial_now;
      e.evicted = evict_now;
      if (ring_fill == 0) begin
         e.last = 1'b1;
         snap_expect_q.push_back(e);
      end else begin
         for (int unsigned i = 0; i < ring_fill; i++) begin
            idx = (ring_wr_slot + LOG_DEPTH - ring_fill + i) % LOG_DEPTH;
            e.entry_valid = 1'b1;
            e.sequence_no = ring_rec[idx].sequence_no;
            e.domain      = ring_rec[idx].domain;
            e.stage       = ring_rec[idx].stage;
            e.code        = ring_rec[idx].code;
            e.ctx         = ring_rec[idx].ctx;
            e.count       = ring_rec[idx].count;
            e.time_ms     = ring_rec[idx].time_ms;
            e.held        = HELD_W'(ring_fill);
            e.last        = (i + 1 == ring_fill);
            snap_expect_q.push_back(e);
         end
      end
   endtask

   task automatic apply_request(logic [1:0] cmd, logic [15:0] dom, logic [15:0] stg,
                                logic [31:0] code, logic [31:0] ctx, logic [31:0] tms);
      case (cmd)
         CMD_RECORD: begin
            n_records++;
            log_fault(dom, stg, code, ctx);
         end
         CMD_SET_TIME: begin
            n_time_sets++;
            model_time = tms;
         end
         CMD_SNAPSHOT: begin
            n_snapshots++;
            queue_snapshot();
         end
         default: begin
            n_dropped++;
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------
   task automatic send_request(logic [1:0] cmd, logic [15:0] dom, logic [15:0] stg,
                               logic [31:0] code, logic [31:0] ctx, logic [31:0] tms);
      // optional sender gap
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_fault_domain  <= dom;
      req_fault_stage   <= stg;
      req_fault_code    <= code;
      req_fault_context <= ctx;
      req_time_ms       <= tms;
      do @(posedge clock); while (!req_ready);
      apply_request(cmd, dom, stg, code, ctx, tms);
   endtask

   task automatic send_record(rec_type sig);
      send_request(CMD_RECORD, sig.domain, sig.stage, sig.code, sig.ctx, $urandom);
   endtask

   task automatic send_snapshot();
      send_request(CMD_SNAPSHOT, 16'($urandom), 16'($urandom), $urandom, $urandom,
                   $urandom);
   endtask

   task automatic send_time(logic [31:0] tms);
      send_request(CMD_SET_TIME, 16'($urandom), 16'($urandom), $urandom, $urandom, tms);
   endtask

   // hold off new requests until every pending result is out
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (snap_expect_q.size() != 0) @(posedge clock);
   endtask

   function automatic rec_type random_sig();
      rec_type s;
      s = '0;
      s.domain = 16'($urandom);
      s.stage  = 16'($urandom);
      s.code   = $urandom;
      s.ctx    = $urandom;
      return s;
   endfunction

   function automatic rec_type make_sig(logic [15:0] dom, logic [15:0] stg,
                                        logic [31:0] code, logic [31:0] ctx);
      rec_type s;
      s = '0;
      s.domain = dom;
      s.stage  = stg;
      s.code   = code;
      s.ctx    = ctx;
      return s;
   endfunction

   // ------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------
   task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v,
                     got_v);
      end
   endtask

   always @(posedge clock) begin : result_check
      snap_entry_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (snap_expect_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result with nothing expected, sequence %h",
                        $realtime, rsp_entry_sequence);
         end else begin
            e = snap_expect_q.pop_front();
            results_checked++;
            report_field("entry_valid", 32'(e.entry_valid), 32'(rsp_entry_valid));
            report_field("entry_sequence", e.sequence_no, rsp_entry_sequence);
            report_field("entry_domain", 32'(e.domain), 32'(rsp_entry_domain));
            report_field("entry_stage", 32'(e.stage), 32'(rsp_entry_stage));
            report_field("entry_code", e.code, rsp_entry_code);
            report_field("entry_context", e.ctx, rsp_entry_context);
            report_field("entry_count", e.count, rsp_entry_count);
            report_field("entry_time", e.time_ms, rsp_entry_time);
            report_field("log_serial", e.serial, rsp_log_serial);
            report_field("evicted_total", e.evicted, rsp_evicted_total);
            report_field("held_count", 32'(e.held), 32'(rsp_held_count));
            report_field("last", 32'(e.last), 32'(rsp_last));
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // empty log gives one invalid result; unused code is dropped
   task automatic test_empty_snapshot();
      send_snapshot();
      send_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF, U32_MAX, U32_MAX, U32_MAX);
      send_snapshot();
   endtask

   // all-zero and all-one fields, board time at both ends
   task automatic test_field_extremes();
      send_time(U32_MAX);
      send_record(make_sig('0, '0, '0, '0));
      send_record(make_sig(16'hFFFF, 16'hFFFF, U32_MAX, U32_MAX));
      send_time('0);
      send_snapshot();
   endtask

   // repeats of the newest record merge; a change in any one field does not
   task automatic test_merge_repeats();
      rec_type a;
      a = make_sig(16'h1234, 16'h0042, 32'hDEAD_0001, 32'h0000_00A5);
      send_record(a);
      send_time(32'd5000);
      send_record(a);
      send_record(a);
      send_record(make_sig(16'h1235, a.stage, a.code, a.ctx));
      send_record(make_sig(16'h1235, 16'h8042, a.code, a.ctx));
      send_record(make_sig(16'h1235, 16'h8042, 32'h5EAD_0001, a.ctx));
      send_record(make_sig(16'h1235, 16'h8042, 32'h5EAD_0001, 32'h8000_00A5));
      send_snapshot();
   endtask

   // fill past DEPTH so the oldest records are overwritten
   task automatic test_ring_wrap();
      for (int i = 0; i < 10; i++) send_record(random_sig());
      send_snapshot();
   endtask

   // sender waits for the whole snapshot before going on
   task automatic test_drain_pause();
      send_snapshot();
      wait_results_drained();
      send_record(random_sig());
      send_snapshot();
      wait_results_drained();
   endtask

   // mostly records drawn so that merges, near misses and wraps are common
   task automatic test_random_traffic(int unsigned n_items, bit with_idle);
      rec_type     pool [4];
      rec_type     last_sig;
      rec_type     sig;
      int unsigned sent;
      int unsigned pick;
      int unsigned kind;
      idle_on = with_idle;
      foreach (pool[i]) pool[i] = random_sig();
      last_sig = pool[0];
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
               sig = last_sig;
            end else if (kind < 7) begin
               sig = pool[$urandom_range(0, 3)];
            end else if (kind < 8) begin
               // near miss: one bit differs from the newest
               sig = last_sig;
               case ($urandom_range(0, 3))
                  0: sig.domain ^= 16'(1) << $urandom_range(0, 15);
                  1: sig.stage  ^= 16'(1) << $urandom_range(0, 15);
                  2: sig.code   ^= 32'(1) << $urandom_range(0, 31);
                  default: sig.ctx ^= 32'(1) << $urandom_range(0, 31);
               endcase
            end else begin
               sig = random_sig();
            end
            if ($urandom_range(0, 19) == 0) pool[$urandom_range(0, 3)] = random_sig();
            send_record(sig);
            last_sig = sig;
            sent++;
         end else if (pick < 75) begin
            send_time($urandom);
            sent++;
         end else if (pick < 89) begin
            send_snapshot();
            sent++;
         end else if (pick < 92) begin
            send_request(CMD_UNUSED, 16'($urandom), 16'($urandom), $urandom, $urandom,
                         $urandom);
         end else if (pick < 94) begin
            wait_results_drained();
         end else begin
            sig = random_sig();
            send_record(sig);
            last_sig = sig;
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      model_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_snapshot();
      test_field_extremes();
      test_merge_repeats();
      test_ring_wrap();
      test_drain_pause();
      test_random_traffic(220, 1'b1);
      test_random_traffic(50, 1'b0);

      // let everything drain, then watch for stray results
      wait_results_drained();
      repeat (40) @(posedge clock);

      $display("Covered %0d records (%0d merged), %0d time sets, %0d snapshots, %0d dropped",
               n_records, n_merged, n_time_sets, n_snapshots, n_dropped);
      $display("Checked %0d results, %0d evictions, %0d mismatches, %0d cycles",
               results_checked, evict_now, mismatch_count, cycle_count);
      if (mismatch_count == 0 && snap_expect_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
